@@ rtl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and codes for the bytecode stack calculator.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

  typedef logic [31:0]        word_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // opcodes
  localparam logic [7:0] OP_ADD  = 8'd1;
  localparam logic [7:0] OP_MUL  = 8'd2;
  localparam logic [7:0] OP_PUSH = 8'd3;

  // parse phases
  localparam logic [1:0] PH_OPCODE = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_VALUE  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

endpackage

@@ rtl/bsc_stack_ram.sv @@
// ----------------------------------------------------------------------------
// bsc_stack_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bsc_stack_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/bytecode_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// bytecode_stack_calculator
// Byte-serial stack machine: ADD, MUL and PUSH immediate on 32-bit words.
// ----------------------------------------------------------------------------
// Program bytes are taken one per transfer. An ADD or MUL that finds two
// words on the stack holds off further bytes (busy) until it completes,
// because the second operand is read from the stack RAM (registered read
// port) while the top of stack sits in a register. The byte marked last
// loads the result register with the popped top and a status (0 ok,
// 1 underflow, 2 overflow, 3 truncated push; word is 0 on error), and the
// machine returns to its empty state. Bytes of the next program are taken
// while a result waits; only a further last byte waits for the result
// register to drain. The stack RAM needs no clearing after reset.
module bytecode_stack_calculator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         code_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_word,
  output logic [1:0]         status
);
  import bsc_pkg::*;

  logic [1:0] phase, phase_next;
  logic [7:0] remaining, remaining_next;
  word_t      accum, accum_next;
  level_t     level, level_next;
  logic [1:0] err, err_next, err_f;
  word_t      tos, tos_next;
  logic       busy, busy_next;
  logic       op_mul, op_mul_next;
  logic       op_last, op_last_next;
  word_t      out_word, out_word_next;
  logic [1:0] out_status, out_status_next;
  logic       out_load;

  logic  in_fire, op_go, start_op, push_en;
  word_t push_val, rd_data, op_res, prod;
  logic  wr_en, rd_en;
  addr_t wr_addr, rd_addr;

  bsc_stack_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(32)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(tos),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_ready = !busy && (!out_valid || out_ready || !last_byte);
  assign in_fire  = in_valid && in_ready;
  assign op_go    = busy && (!op_last || !out_valid || out_ready);
  assign prod     = tos * rd_data;
  assign op_res   = op_mul ? prod : tos + rd_data;

  always_comb begin
    phase_next      = phase;
    remaining_next  = remaining;
    accum_next      = accum;
    level_next      = level;
    err_next        = err;
    tos_next        = tos;
    busy_next       = busy;
    op_mul_next     = op_mul;
    op_last_next    = op_last;
    out_load        = 1'b0;
    out_word_next   = out_word;
    out_status_next = out_status;
    err_f           = err;
    start_op        = 1'b0;
    push_en         = 1'b0;
    push_val        = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;

    if (op_go) begin
      tos_next   = op_res;
      level_next = level - level_t'(1);
      busy_next  = 1'b0;
      if (op_last) begin
        out_load        = 1'b1;
        out_word_next   = op_res;
        out_status_next = ST_OK;
        phase_next      = PH_OPCODE;
        remaining_next  = '0;
        accum_next      = '0;
        level_next      = '0;
        err_next        = ST_OK;
      end
    end else if (in_fire) begin
      unique case (phase)
        PH_OPCODE: begin
          if (code_byte == OP_ADD || code_byte == OP_MUL) begin
            if (err == ST_OK) begin
              if (level < level_t'(2)) begin
                err_next = ST_UNDER;
              end else begin
                start_op     = 1'b1;
                busy_next    = 1'b1;
                op_mul_next  = (code_byte == OP_MUL);
                op_last_next = last_byte;
                rd_en        = 1'b1;
                rd_addr      = addr_t'(level - level_t'(2));
              end
            end
          end else if (code_byte == OP_PUSH) begin
            phase_next = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          accum_next = '0;
          if (code_byte == 8'd0) begin
            push_en    = 1'b1;
            push_val   = '0;
            phase_next = PH_OPCODE;
          end else begin
            remaining_next = code_byte;
            phase_next     = PH_VALUE;
          end
        end
        PH_VALUE: begin
          accum_next     = {accum[23:0], code_byte};
          remaining_next = remaining - 8'd1;
          if (remaining_next == 8'd0) begin
            push_en    = 1'b1;
            push_val   = accum_next;
            phase_next = PH_OPCODE;
          end
        end
        default: begin
          phase_next = PH_OPCODE;
        end
      endcase

      if (push_en && err == ST_OK) begin
        if (level == level_t'(STACK_DEPTH)) begin
          err_next = ST_OVER;
        end else begin
          // spill old top below the new one
          if (level != '0) begin
            wr_en   = 1'b1;
            wr_addr = addr_t'(level - level_t'(1));
          end
          tos_next   = push_val;
          level_next = level + level_t'(1);
        end
      end

      if (last_byte && !start_op) begin
        err_f = err_next;
        if (phase_next != PH_OPCODE && err_f == ST_OK) begin
          err_f = ST_TRUNC;
        end
        if (err_f == ST_OK && level_next == '0) begin
          err_f = ST_UNDER;
        end
        out_load        = 1'b1;
        out_status_next = err_f;
        out_word_next   = (err_f == ST_OK) ? tos_next : '0;
        phase_next      = PH_OPCODE;
        remaining_next  = '0;
        accum_next      = '0;
        level_next      = '0;
        err_next        = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OPCODE;
      remaining <= '0;
      accum     <= '0;
      level     <= '0;
      err       <= ST_OK;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
      accum     <= accum_next;
      level     <= level_next;
      err       <= err_next;
      busy      <= busy_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tos        <= tos_next;
    op_mul     <= op_mul_next;
    op_last    <= op_last_next;
    out_word   <= out_word_next;
    out_status <= out_status_next;
  end

  assign result_word = $signed(out_word);
  assign status      = out_status;

  a_op_depth: assert property (@(posedge clk) disable iff (rst)
    busy |-> level >= level_t'(2))
    else $error("binary op in flight with fewer than two words");

  a_level_max: assert property (@(posedge clk) disable iff (rst)
    level <= level_t'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> result_word == 32'sd0)
    else $error("nonzero word with error status");

  a_end_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (level == '0 && phase == PH_OPCODE && err == ST_OK && !busy))
    else $error("state not cleared after program end");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != ST_OK && !out_load) |=> $stable(err))
    else $error("error code changed within a program");

endmodule
